// File: design/rwf_pkg.sv
// ----------------------------------------------------------------------------
// rwf_pkg: shared types and codes of the RGB 3x3 window filter
// Word formats, the emit tag that travels down the pipeline, filter modes and
// register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rwf_pkg;

    typedef logic [23:0] t_pixel;
    typedef logic [8:0][23:0] t_window;

    typedef struct packed {
        logic       action;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } t_out_item;

    // Travels with a shift that produces a result word.
    typedef struct packed {
        logic interior;
        logic frame_end;
    } t_emit_info;

    localparam logic ACT_PAD = 1'b1;

    localparam logic [2:0] MODE_MAX     = 3'd0;
    localparam logic [2:0] MODE_MIN     = 3'd1;
    localparam logic [2:0] MODE_MEAN    = 3'd2;
    localparam logic [2:0] MODE_SOBEL_H = 3'd3;
    localparam logic [2:0] MODE_SOBEL_V = 3'd4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam int OFIFO_DEPTH = 8;
    localparam int FIFO_AW     = $clog2(OFIFO_DEPTH);

endpackage

`default_nettype wire

// File: design/rwf_ram.sv
// ----------------------------------------------------------------------------
// rwf_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and returns the
// old contents when the same entry is written in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rwf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/rwf_window.sv
// ----------------------------------------------------------------------------
// rwf_window: line memory and 3x3 window
// Reads the upper and middle line entries of a column, writes them back moved
// up by one line, and shifts the column into the 3x3 window.
// ----------------------------------------------------------------------------
`default_nettype none

module rwf_window #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  rwf_pkg::t_pixel              i_px,
    input  logic                         i_emit,
    input  rwf_pkg::t_emit_info          i_info,
    output logic                         o_vld,
    output rwf_pkg::t_emit_info          o_info,
    output rwf_pkg::t_window             o_win
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic                r_s1_vld;
    logic                r_s1_emit;
    logic [AW-1:0]       r_s1_addr;
    rwf_pkg::t_pixel     r_s1_px;
    rwf_pkg::t_emit_info r_s1_info;

    logic                r_fwd_vld;
    logic [AW-1:0]       r_fwd_addr;
    rwf_pkg::t_pixel     r_fwd_mid;
    rwf_pkg::t_pixel     r_fwd_px;

    rwf_pkg::t_window    r_win;
    rwf_pkg::t_window    n_win;
    logic                r_out_vld;
    rwf_pkg::t_emit_info r_out_info;

    logic [47:0]         ram_rdata;
    rwf_pkg::t_pixel     top_px;
    rwf_pkg::t_pixel     mid_px;

    rwf_ram #(
        .WIDTH (48),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_addr),
        .i_wdata ({mid_px, r_s1_px}),
        .i_re    (i_shift),
        .i_raddr (i_addr),
        .o_rdata (ram_rdata)
    );

    // The previous shift wrote this column on the same edge that our read
    // sampled it, so the memory returned stale data.
    always_comb begin
        top_px = ram_rdata[47:24];
        mid_px = ram_rdata[23:0];
        if (r_fwd_vld && r_fwd_addr == r_s1_addr) begin
            top_px = r_fwd_mid;
            mid_px = r_fwd_px;
        end
    end

    always_comb begin
        n_win = r_win;
        if (r_s1_vld) begin
            for (int i = 0; i < 3; i++) begin
                n_win[i*3]   = r_win[i*3+1];
                n_win[i*3+1] = r_win[i*3+2];
            end
            n_win[2] = top_px;
            n_win[5] = mid_px;
            n_win[8] = r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_emit <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_win     <= '0;
        end else begin
            r_s1_vld  <= i_shift;
            r_s1_emit <= i_shift & i_emit;
            r_fwd_vld <= r_s1_vld;
            r_out_vld <= r_s1_vld & r_s1_emit;
            r_win     <= n_win;
        end
        r_s1_addr  <= i_addr;
        r_s1_px    <= i_px;
        r_s1_info  <= i_info;
        r_fwd_addr <= r_s1_addr;
        r_fwd_mid  <= mid_px;
        r_fwd_px   <= r_s1_px;
        r_out_info <= r_s1_info;
    end

    assign o_vld  = r_out_vld;
    assign o_info = r_out_info;
    assign o_win  = r_win;

endmodule

`default_nettype wire

// File: design/rwf_kernel.sv
// ----------------------------------------------------------------------------
// rwf_kernel: per-channel window arithmetic
// First stage reduces the window to max, min, sum or Sobel magnitude; second
// stage divides mean and Sobel by nine (reciprocal multiply), restores sign.
// ----------------------------------------------------------------------------
`default_nettype none

module rwf_kernel (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  rwf_pkg::t_emit_info i_info,
    input  rwf_pkg::t_window    i_win,
    input  logic [2:0]          i_mode,
    output logic                o_vld,
    output rwf_pkg::t_out_item  o_item
);

    // floor(x * RECIP9 / 2^16) equals floor(x / 9) for every x below 32768.
    localparam logic [12:0] RECIP9 = 13'd7282;

    typedef struct packed {
        logic [11:0] val;
        logic        neg;
        logic        div;
    } t_red;

    function automatic t_red reduce_chan(input logic [8:0][7:0] v, input logic [2:0] mode,
                                         input logic interior);
        logic [7:0]  mx;
        logic [7:0]  mn;
        logic [11:0] sum;
        logic [9:0]  a;
        logic [9:0]  b;
        t_red        r;
        mx  = v[0];
        mn  = v[0];
        sum = 12'(v[0]);
        for (int i = 1; i < 9; i++) begin
            if (v[i] > mx) mx = v[i];
            if (v[i] < mn) mn = v[i];
            sum = sum + 12'(v[i]);
        end
        a     = 10'(v[0]) + {1'b0, v[3], 1'b0} + 10'(v[6]);
        b     = 10'(v[2]) + {1'b0, v[5], 1'b0} + 10'(v[8]);
        if (mode == rwf_pkg::MODE_SOBEL_H) begin
            a = 10'(v[0]) + {1'b0, v[1], 1'b0} + 10'(v[2]);
            b = 10'(v[6]) + {1'b0, v[7], 1'b0} + 10'(v[8]);
        end
        r.val = 12'(v[4]);
        r.neg = 1'b0;
        r.div = 1'b0;
        if (interior) begin
            case (mode) inside
                rwf_pkg::MODE_MAX: r.val = 12'(mx);
                rwf_pkg::MODE_MIN: r.val = 12'(mn);
                rwf_pkg::MODE_MEAN: begin
                    r.val = sum;
                    r.div = 1'b1;
                end
                rwf_pkg::MODE_SOBEL_H, rwf_pkg::MODE_SOBEL_V: begin
                    r.div = 1'b1;
                    if (a >= b) begin
                        r.val = 12'(a - b);
                    end else begin
                        r.val = 12'(b - a);
                        r.neg = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    t_red       r_red [3];
    t_red       n_red [3];
    logic       r_vld;
    logic       r_frame_end;
    logic [7:0] res [3];

    always_comb begin
        logic [8:0][7:0] v;
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 9; i++) begin
                v[i] = i_win[i][8*(2-c) +: 8];
            end
            n_red[c] = reduce_chan(v, i_mode, i_info.interior);
        end
    end

    always_comb begin
        logic [24:0] prod;
        logic [7:0]  q;
        for (int c = 0; c < 3; c++) begin
            prod = 25'(r_red[c].val) * 25'(RECIP9);
            q    = prod[23:16];
            if (!r_red[c].div) begin
                res[c] = r_red[c].val[7:0];
            end else if (r_red[c].neg) begin
                res[c] = 8'(8'd0 - q);
            end else begin
                res[c] = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_red       <= n_red;
        r_frame_end <= i_info.frame_end;
    end

    assign o_vld            = r_vld;
    assign o_item.out_red   = res[0];
    assign o_item.out_green = res[1];
    assign o_item.out_blue  = res[2];
    assign o_item.frame_end = r_frame_end;

endmodule

`default_nettype wire

// File: design/rwf_out_fifo.sv
// ----------------------------------------------------------------------------
// rwf_out_fifo: result word queue
// Holds finished result words until the output side takes them, so the
// arithmetic pipeline never has to stop.
// ----------------------------------------------------------------------------
`default_nettype none

module rwf_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rwf_pkg::t_out_item i_item,
    input  logic               i_pop,
    output logic               o_vld,
    output rwf_pkg::t_out_item o_item
);

    localparam int AW = rwf_pkg::FIFO_AW;

    rwf_pkg::t_out_item r_mem [rwf_pkg::OFIFO_DEPTH];
    logic [AW-1:0]      r_wp;
    logic [AW-1:0]      r_rp;
    logic [AW:0]        r_cnt;
    logic               pop_ok;

    assign pop_ok = i_pop && r_cnt != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (pop_ok) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(pop_ok);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_vld  = r_cnt != '0;
    assign o_item = r_mem[r_rp];

endmodule

`default_nettype wire

// File: design/rgb_window3x3_filter.sv
// ----------------------------------------------------------------------------
// rgb_window3x3_filter: 3x3 max/min/mean/Sobel filter on an RGB raster stream
// Pipeline: the input word that produces a result word passes a registered
//   memory read, window shift and reduce, then the scale and output queue.
// Throughput: one input word per clock; o_in_stall rises only when eight
//   result words are outstanding on a stalled output.
// Reset: positions, window and queue clear at once; the line memory is not
//   cleared and needs no clearing pass. Geometry writes restart the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_window3x3_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rwf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rwf_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int CMPW = (CW + 1 > 11) ? CW + 1 : 11;
    localparam int CMPR = (RW + 1 > 11) ? RW + 1 : 11;
    localparam int PW   = CMPW + 1;
    localparam int UW   = rwf_pkg::FIFO_AW + 1;

    localparam logic [10:0] W_MAX = (MAX_WIDTH > 2047) ? 11'd2047 : 11'(MAX_WIDTH);
    localparam logic [10:0] H_MAX = (MAX_HEIGHT > 2047) ? 11'd2047 : 11'(MAX_HEIGHT);
    localparam logic [10:0] W_RST = (MAX_WIDTH < 640) ? W_MAX : 11'd640;
    localparam logic [10:0] H_RST = (MAX_HEIGHT < 480) ? H_MAX : 11'd480;

    function automatic logic [10:0] clamp_dim(input logic [10:0] x, input logic [10:0] hi);
        logic [10:0] y;
        y = x;
        if (y < 11'd3) y = 11'd3;
        if (y > hi) y = hi;
        return y;
    endfunction

    logic [10:0]   r_width, n_width;
    logic [10:0]   r_height, n_height;
    logic [2:0]    r_mode, n_mode;
    logic [CW-1:0] r_in_col, n_in_col;
    logic [RW-1:0] r_in_row, n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;
    logic [PW-1:0] r_pend, n_pend;
    logic [UW-1:0] r_used, n_used;

    logic in_acc, out_acc, cfg_wr, geom_wr;
    logic is_pad, pad_ok, do_shift, do_emit;
    logic in_col_last, in_row_last, out_col_last, out_row_last;

    logic [CW-1:0]       sh_addr;
    rwf_pkg::t_pixel     sh_px;
    rwf_pkg::t_emit_info sh_info;

    logic                win_vld;
    rwf_pkg::t_emit_info win_info;
    rwf_pkg::t_window    win;
    logic                k_vld;
    rwf_pkg::t_out_item  k_item;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign geom_wr = cfg_wr && (paddr[3:2] == rwf_pkg::REG_WIDTH ||
                                paddr[3:2] == rwf_pkg::REG_HEIGHT);

    always_comb begin
        unique case (paddr[3:2])
            rwf_pkg::REG_WIDTH:  prdata = 32'(r_width);
            rwf_pkg::REG_HEIGHT: prdata = 32'(r_height);
            rwf_pkg::REG_MODE:   prdata = 32'(r_mode);
            default:             prdata = 32'd0;
        endcase
    end

    assign o_in_stall = r_used == UW'(rwf_pkg::OFIFO_DEPTH);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = o_out_valid && !i_out_stall;

    assign in_col_last  = CMPW'(r_in_col) + CMPW'(1) >= CMPW'(r_width);
    assign in_row_last  = CMPR'(r_in_row) + CMPR'(1) >= CMPR'(r_height);
    assign out_col_last = CMPW'(r_out_col) + CMPW'(1) >= CMPW'(r_width);
    assign out_row_last = CMPR'(r_out_row) + CMPR'(1) >= CMPR'(r_height);

    // A pad only drains the tail of a frame whose last pixel has arrived.
    assign is_pad   = i_in_data.action == rwf_pkg::ACT_PAD;
    assign pad_ok   = r_in_col == '0 && r_in_row == '0 && r_pend != '0;
    assign do_shift = in_acc && (!is_pad || pad_ok);
    // A pixel emits once the window center trails it by a row plus a pixel.
    assign do_emit  = do_shift &&
                      (is_pad || r_pend == PW'(r_width) + PW'(1));

    assign sh_addr = !is_pad ? r_in_col : (out_col_last ? '0 : r_out_col + CW'(1));
    assign sh_px   = is_pad ? '0 : {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};

    assign sh_info.interior  = r_out_row != '0 &&
                               CMPR'(r_out_row) + CMPR'(2) <= CMPR'(r_height) &&
                               r_out_col != '0 &&
                               CMPW'(r_out_col) + CMPW'(2) <= CMPW'(r_width);
    assign sh_info.frame_end = out_row_last && out_col_last;

    always_comb begin
        n_width   = r_width;
        n_height  = r_height;
        n_mode    = r_mode;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_pend    = r_pend;
        n_used    = r_used + UW'(do_emit) - UW'(out_acc);
        if (cfg_wr) begin
            unique case (paddr[3:2])
                rwf_pkg::REG_WIDTH:  n_width  = clamp_dim(pwdata[10:0], W_MAX);
                rwf_pkg::REG_HEIGHT: n_height = clamp_dim(pwdata[10:0], H_MAX);
                rwf_pkg::REG_MODE:   n_mode   = pwdata[2:0];
                default: ;
            endcase
        end
        if (geom_wr) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_pend    = '0;
        end else begin
            if (in_acc && !is_pad) begin
                if (in_col_last) begin
                    n_in_col = '0;
                    n_in_row = in_row_last ? '0 : r_in_row + RW'(1);
                end else begin
                    n_in_col = r_in_col + CW'(1);
                end
                n_pend = do_emit ? r_pend : r_pend + PW'(1);
            end else if (do_shift) begin
                n_pend = r_pend - PW'(1);
            end
            if (do_emit) begin
                if (out_col_last) begin
                    n_out_col = '0;
                    n_out_row = out_row_last ? '0 : r_out_row + RW'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= W_RST;
            r_height  <= H_RST;
            r_mode    <= rwf_pkg::MODE_MAX;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pend    <= '0;
            r_used    <= '0;
        end else begin
            r_width   <= n_width;
            r_height  <= n_height;
            r_mode    <= n_mode;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pend    <= n_pend;
            r_used    <= n_used;
        end
    end

    rwf_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (do_shift),
        .i_addr  (sh_addr),
        .i_px    (sh_px),
        .i_emit  (do_emit),
        .i_info  (sh_info),
        .o_vld   (win_vld),
        .o_info  (win_info),
        .o_win   (win)
    );

    rwf_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (win_vld),
        .i_info  (win_info),
        .i_win   (win),
        .i_mode  (r_mode),
        .o_vld   (k_vld),
        .o_item  (k_item)
    );

    rwf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (k_vld),
        .i_item  (k_item),
        .i_pop   (out_acc),
        .o_vld   (o_out_valid),
        .o_item  (o_out_data)
    );

    // Results owed never exceed one row plus one pixel between emits.
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PW'(r_width) + PW'(1))
        else $error("pending result count beyond one row plus one pixel");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(rwf_pkg::OFIFO_DEPTH))
        else $error("outstanding result words exceed queue depth");

    a_out_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_out_col) < CMPW'(r_width) && CMPR'(r_out_row) < CMPR'(r_height))
        else $error("output position outside the frame");

    a_emit_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_emit && is_pad |=> r_pend == $past(r_pend) - PW'(1))
        else $error("pad emit did not consume a pending result");

endmodule

`default_nettype wire
